// ===== rtl/dsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and the degree arctangent function of the sine and
// cosine pipeline.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 30;
  localparam int CORDIC_STEPS_DEF    = 24;

  localparam int ANGLE_W    = 32;
  localparam int OUT_W      = 32;
  localparam int OUT_DATA_W = 2 * OUT_W;
  localparam int WORK_FRAC  = 30;
  localparam int XW         = 34;
  localparam int ZW         = 38;

  localparam logic signed [XW-1:0] INV_GAIN       = 34'sh0_26DD_3B6A;
  localparam logic [63:0]          QUARTER_PI_Q62 = 64'h3243_F6A8_885A_308D;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } dsc_quad_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    dsc_quad_t            quad;
    logic                 exact;
  } dsc_work_t;

  // Restoring long division, used only while the arctangent constants are elaborated.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-step in degrees with 30 fraction bits. The series for
  // atan is summed with 62 fraction bits, divided by a quarter of pi and
  // scaled by 45 degrees with rounding.
  function automatic logic [63:0] atan_deg(input int step);
    logic [63:0] sum;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] term;
    logic [63:0] odd;
    int          e;
    if (step == 0) begin
      return 64'd45 << WORK_FRAC;
    end
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e   = step * (2 * k + 1);
      odd = 64'(2 * k + 1);
      if (e <= 62) begin
        term = long_div(64'd1 << (62 - e), odd);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rem = sum;
    quo = '0;
    for (int b = 0; b < 36; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= QUARTER_PI_Q62) begin
        rem = rem - QUARTER_PI_Q62;
        quo = quo | 64'd1;
      end
    end
    return (quo * 64'd45 + 64'd32) >> 6;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dsc_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_reduce
// Three-stage angle reduction: splits the angle into a quadrant and a
// residual in [-45, 45) degrees and seeds the rotation pipeline.
// ----------------------------------------------------------------------------
module dsc_reduce
  import dsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [ANGLE_W-1:0] in_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dsc_work_t               out_work
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int GW  = ANGLE_W - F;
  localparam int UW  = GW + 5;
  localparam int SH  = UW + 6;
  localparam int RCW = UW + 1;
  localparam int PW  = UW + RCW;
  localparam int RDW = F + 9;

  localparam logic signed [ANGLE_W:0] P45     = (ANGLE_W + 1)'(45) <<< F;
  localparam logic [UW-1:0]           OFF     = UW'(45) << (GW - 1);
  localparam logic [RCW-1:0]          RECIP   = RCW'((64'd1 << SH) / 64'd45);
  localparam logic [RDW-1:0]          P45_RES = RDW'(45) << F;

  logic            v1_r, v2_r, v3_r;
  logic            en1, en2, en3;
  logic [UW-1:0]   gu1_r, gu2_r;
  logic [F:0]      lo1_r, lo2_r;
  logic [GW-1:0]   qe_r;
  dsc_work_t       work_r;

  logic signed [ANGLE_W:0] u;
  logic [UW-1:0]           gu_nxt;
  logic [PW-1:0]           prod;
  logic [UW-1:0]           qe45;
  logic [UW-1:0]           rem0;
  logic                    wrap;
  logic [5:0]              rem;
  logic signed [RDW-1:0]   resid;
  dsc_work_t               work_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign u      = $signed({in_angle[ANGLE_W-1], in_angle}) + P45;
  assign gu_nxt = {{5{u[ANGLE_W]}}, u[ANGLE_W:F+1]} + OFF;

  assign prod = PW'(gu1_r) * PW'(RECIP);

  assign qe45  = UW'(qe_r) * UW'(45);
  assign rem0  = gu2_r - qe45;
  assign wrap  = rem0[6:0] >= 7'd45;
  assign rem   = wrap ? 6'(rem0[6:0] - 7'd45) : rem0[5:0];
  assign resid = $signed({2'b00, rem, lo2_r} - P45_RES);

  always_comb begin
    work_nxt       = '0;
    work_nxt.x     = INV_GAIN;
    work_nxt.y     = '0;
    work_nxt.z     = ZW'(resid) <<< (WORK_FRAC - F);
    work_nxt.quad  = dsc_quad_t'(qe_r[1:0] + {1'b0, wrap});
    work_nxt.exact = (resid == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      gu1_r <= gu_nxt;
      lo1_r <= u[F:0];
    end
    if (en2 && v1_r) begin
      qe_r  <= prod[SH +: GW];
      gu2_r <= gu1_r;
      lo2_r <= lo1_r;
    end
    if (en3 && v2_r) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_work  = work_r;

endmodule
`default_nettype wire

// ===== rtl/dsc_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_cordic_stage
// One registered CORDIC rotation step with a fixed shift and a fixed
// degree arctangent.
// ----------------------------------------------------------------------------
module dsc_cordic_stage
  import dsc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dsc_work_t in_work,
  output logic           out_valid,
  input  wire logic      out_ready,
  output dsc_work_t      out_work
);

  localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_deg(STEP)));

  logic                 valid_r;
  logic                 en;
  dsc_work_t            work_r;
  dsc_work_t            work_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;
  assign dx       = in_work.y >>> STEP;
  assign dy       = in_work.x >>> STEP;

  always_comb begin
    work_nxt = in_work;
    if (!in_work.z[ZW-1]) begin
      work_nxt.x = in_work.x - dx;
      work_nxt.y = in_work.y + dy;
      work_nxt.z = in_work.z - ATAN;
    end else begin
      work_nxt.x = in_work.x + dx;
      work_nxt.y = in_work.y - dy;
      work_nxt.z = in_work.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule
`default_nettype wire

// ===== rtl/degree_sine_cosine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// degree_sine_cosine
// Pipelined sine and cosine of a fixed-point angle given in degrees.
// ----------------------------------------------------------------------------
// The input channel carries one angle per request, signed, with
// ANGLE_FRAC_BITS fraction bits. The result channel returns one request per
// angle holding the sine and the cosine, signed, with OUT_FRAC_BITS fraction
// bits and clamped to plus or minus one. Exact multiples of 90 degrees give
// exact results.
// From acceptance, an angle passes the angle reduction stages, the rotation
// steps and a final register for quadrant mapping, rounding and clamping
// before its result is presented. Throughput is one angle per cycle while
// the receiver keeps up; every stage holds its own register.
// When the receiver stalls, the full stages hold their contents and empty
// stages keep filling, so the block takes new angles until the pipeline is
// full; nothing is dropped or repeated. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module degree_sine_cosine
  import dsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ANGLE_W-1:0]    in_tdata,   // [31:0] angle_deg
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [31:0] sine, [63:32] cosine
);

  localparam int RSH = WORK_FRAC - OUT_FRAC_BITS;

  localparam logic signed [XW-1:0] ONE     = $signed(XW'(64'd1 << OUT_FRAC_BITS));
  localparam logic signed [XW-1:0] NEG_ONE = -ONE;

  logic      v_chain [CORDIC_STEPS+1];
  logic      r_chain [CORDIC_STEPS+1];
  dsc_work_t w_chain [CORDIC_STEPS+1];

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  en_out;

  logic signed [XW-1:0] sel_s, sel_c;
  logic signed [XW-1:0] rnd_s, rnd_c;
  logic signed [XW-1:0] sat_s, sat_c;
  logic signed [XW-1:0] ex_s, ex_c;
  dsc_work_t            fin;

  dsc_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_angle  (in_tdata),
    .out_valid (v_chain[0]),
    .out_ready (r_chain[0]),
    .out_work  (w_chain[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    dsc_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_chain[i]),
      .in_ready  (r_chain[i]),
      .in_work   (w_chain[i]),
      .out_valid (v_chain[i+1]),
      .out_ready (r_chain[i+1]),
      .out_work  (w_chain[i+1])
    );
  end

  assign fin                   = w_chain[CORDIC_STEPS];
  assign en_out                = !out_valid_r || out_tready;
  assign r_chain[CORDIC_STEPS] = en_out;

  always_comb begin
    unique case (fin.quad)
      QUAD_0: begin
        sel_s = fin.y;
        sel_c = fin.x;
        ex_s  = '0;
        ex_c  = ONE;
      end
      QUAD_90: begin
        sel_s = fin.x;
        sel_c = -fin.y;
        ex_s  = ONE;
        ex_c  = '0;
      end
      QUAD_180: begin
        sel_s = -fin.y;
        sel_c = -fin.x;
        ex_s  = '0;
        ex_c  = NEG_ONE;
      end
      QUAD_270: begin
        sel_s = -fin.x;
        sel_c = fin.y;
        ex_s  = NEG_ONE;
        ex_c  = '0;
      end
      default: begin
        sel_s = fin.y;
        sel_c = fin.x;
        ex_s  = '0;
        ex_c  = ONE;
      end
    endcase
  end

  if (RSH > 0) begin : g_round
    localparam logic signed [XW-1:0] HALF = $signed(XW'(64'd1 << (RSH - 1)));
    assign rnd_s = (sel_s + HALF) >>> RSH;
    assign rnd_c = (sel_c + HALF) >>> RSH;
  end else begin : g_no_round
    assign rnd_s = sel_s;
    assign rnd_c = sel_c;
  end

  assign sat_s = (rnd_s > ONE) ? ONE : ((rnd_s < NEG_ONE) ? NEG_ONE : rnd_s);
  assign sat_c = (rnd_c > ONE) ? ONE : ((rnd_c < NEG_ONE) ? NEG_ONE : rnd_c);

  always_comb begin
    if (fin.exact) begin
      out_data_nxt = {ex_c[OUT_W-1:0], ex_s[OUT_W-1:0]};
    end else begin
      out_data_nxt = {sat_c[OUT_W-1:0], sat_s[OUT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v_chain[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v_chain[CORDIC_STEPS]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== dv/degree_sine_cosine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_sine_cosine_tb
// Self-checking bench for the degree sine and cosine pipeline.
// ----------------------------------------------------------------------------
// Angles are sent as stream requests and each result request is compared
// with a bit-exact prediction made when its angle is accepted. Directed
// angles cover the exact quarter turns, the half-quadrant boundary, the
// extremes of the input word and values next to saturation. Random angles
// follow, in phases with and without idling on either side, and the bench
// drains the pipeline between phases.
// ----------------------------------------------------------------------------
module degree_sine_cosine_tb;
  import dsc_pkg::*;

  localparam int  STEPS      = CORDIC_STEPS_DEF;
  localparam int  SHIFT_IN   = WORK_FRAC - ANGLE_FRAC_BITS_DEF;
  localparam int  DEG_90     = 90 << ANGLE_FRAC_BITS_DEF;
  localparam int  DEG_45     = DEG_90 / 2;
  localparam int  DEG_360    = 4 * DEG_90;
  localparam longint UNIT    = longint'(1) << OUT_FRAC_BITS_DEF;
  localparam int  PHASE_LEN  = 200;

  typedef struct packed {
    logic signed [OUT_W-1:0] cosine;
    logic signed [OUT_W-1:0] sine;
  } trig_pair_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [ANGLE_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  longint unsigned atan_table [STEPS];
  int              angle_q [$];
  trig_pair_t      expected_q [$];
  int              angles_queued   = 0;
  int              angles_accepted = 0;
  int              error_count     = 0;
  int              send_idle_pct   = 0;
  int              recv_stall_pct  = 0;
  logic            in_taken        = 1'b0;

  degree_sine_cosine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Arctangent of 2^-i in degrees with 30 fraction bits, from the odd power
  // series divided by a quarter of pi and scaled by 45 degrees.
  function automatic void build_atan_table();
    longint unsigned sum;
    longint unsigned rem;
    longint unsigned quo;
    longint unsigned term;
    int              e;
    atan_table[0] = longint'(45) << WORK_FRAC;
    for (int i = 1; i < STEPS; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        e    = i * (2 * k + 1);
        term = (longint'(1) << (62 - e)) / longint'(2 * k + 1);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rem = sum;
      quo = 0;
      for (int b = 0; b < 36; b++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= QUARTER_PI_Q62) begin
          rem = rem - QUARTER_PI_Q62;
          quo = quo | 1;
        end
      end
      atan_table[i] = (quo * 45 + 32) >> 6;
    end
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT) begin
      return UNIT;
    end
    if (v < -UNIT) begin
      return -UNIT;
    end
    return v;
  endfunction

  function automatic trig_pair_t predict_sin_cos(input logic [ANGLE_W-1:0] angle);
    longint     m;
    longint     q;
    longint     r;
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    longint     s;
    longint     c;
    trig_pair_t res;
    m = longint'($signed(angle)) % DEG_360;
    if (m < 0) begin
      m = m + DEG_360;
    end
    if (m % DEG_90 == 0) begin
      case (dsc_quad_t'(2'(m / DEG_90)))
        QUAD_0:   begin s = 0;     c = UNIT;  end
        QUAD_90:  begin s = UNIT;  c = 0;     end
        QUAD_180: begin s = 0;     c = -UNIT; end
        default:  begin s = -UNIT; c = 0;     end
      endcase
    end else begin
      q = (m + DEG_45) / DEG_90;
      r = m - q * DEG_90;
      x = longint'(INV_GAIN);
      y = 0;
      z = r <<< SHIFT_IN;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(atan_table[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(atan_table[i]);
        end
      end
      case (dsc_quad_t'(q[1:0]))
        QUAD_0:   begin s = y;  c = x;  end
        QUAD_90:  begin s = x;  c = -y; end
        QUAD_180: begin s = -y; c = -x; end
        default:  begin s = -x; c = y;  end
      endcase
      s = clamp_unit(s);
      c = clamp_unit(c);
    end
    res.sine   = OUT_W'(s);
    res.cosine = OUT_W'(c);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (angle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= angle_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are checked before new angles are predicted so that the store of
  // expected pairs is touched by one process only.
  always @(posedge clk) begin
    trig_pair_t got;
    trig_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result request %h", out_tdata));
      end else begin
        want = expected_q.pop_front();
        if (got.sine !== want.sine) begin
          report_mismatch($sformatf("sine %h, predicted %h", got.sine, want.sine));
        end
        if (got.cosine !== want.cosine) begin
          report_mismatch($sformatf("cosine %h, predicted %h", got.cosine, want.cosine));
        end
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_q.push_back(predict_sin_cos(in_tdata));
      angles_accepted++;
    end
  end

  task automatic drain_pipeline();
    while (angles_accepted != angles_queued || expected_q.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  initial begin
    int directed [$];
    int send_pct [4];
    int recv_pct [4];
    int angle;
    send_pct = '{0, 62, 0, 36};
    recv_pct = '{0, 0, 62, 36};
    directed = '{0, DEG_90, 2 * DEG_90, 3 * DEG_90, DEG_360, -DEG_90, -DEG_360,
                 32'h7FFF_FFFF, 32'h8000_0000, DEG_45, -DEG_45, 3 * DEG_45,
                 5 * DEG_45, 7 * DEG_45, DEG_45 - 1, 1, -1, DEG_90 - 1, DEG_90 + 1,
                 30 << ANGLE_FRAC_BITS_DEF, -(60 << ANGLE_FRAC_BITS_DEF),
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF};
    build_atan_table();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      angle_q.push_back(directed[i]);
      angles_queued++;
    end
    drain_pipeline();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int n = 0; n < PHASE_LEN; n++) begin
        case ($urandom_range(7))
          0, 1:    angle = $urandom;
          2:       angle = int'($urandom_range(94371840)) - 47185920;
          3:       angle = (int'($urandom_range(728)) - 364) * DEG_90;
          4:       angle = (int'($urandom_range(1456)) - 728) * DEG_45
                           + int'($urandom_range(6)) - 3;
          5:       angle = (int'($urandom_range(728)) - 364) * DEG_90
                           + int'($urandom_range(512)) - 256;
          6:       angle = $urandom & $urandom;
          default: angle = $urandom | $urandom;
        endcase
        angle_q.push_back(angle);
        angles_queued++;
      end
      // The next phase is queued only once every result of this phase is back.
      drain_pipeline();
    end
    repeat (STEPS + 16) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== degree_sine_cosine.f =====
rtl/dsc_pkg.sv
rtl/dsc_reduce.sv
rtl/dsc_cordic_stage.sv
rtl/degree_sine_cosine.sv
dv/degree_sine_cosine_tb.sv
